// ----- src/imm_pkg.sv -----
package imm_pkg;

    // Fixed widths of the item fields and configuration registers.
    localparam int SIZE_BITS    = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int INDEX_BITS   = 3;
    localparam int VALUE_BITS   = 16;
    localparam int PRODUCT_BITS = 36;
    localparam int COUNT_BITS   = 11;
    localparam int OP_BITS      = 2;

    // Two operations (one multiply, one add) per multiply-add.
    localparam int OPS_PER_MAC  = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_START   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic run;     // a multiply-add is issued this cycle unless stalled
        logic first;   // first term of a product element
        logic last_k;  // last term of a product element
        logic fin;     // last term of the whole product
        logic clear;   // a start was accepted
        logic wr_a;    // write the input element into A
        logic wr_b;    // write the input element into B
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic stall;   // result register full and not taken
        logic busy;    // multiply-adds still in the pipeline
    } stat_t;

endpackage

// ----- src/imm_if.sv -----
interface imm_cmd_if;
    logic                                      valid;
    logic                                      ready;
    logic [imm_pkg::OP_BITS-1:0]               operation;
    logic [imm_pkg::INDEX_BITS-1:0]            row_index;
    logic [imm_pkg::INDEX_BITS-1:0]            col_index;
    logic signed [imm_pkg::VALUE_BITS-1:0]     element_value;

    modport source (
        output valid, operation, row_index, col_index, element_value,
        input  ready
    );
    modport sink (
        input  valid, operation, row_index, col_index, element_value,
        output ready
    );
endinterface

interface imm_result_if;
    logic                                      valid;
    logic                                      ready;
    logic [imm_pkg::INDEX_BITS-1:0]            out_row;
    logic [imm_pkg::INDEX_BITS-1:0]            out_col;
    logic signed [imm_pkg::PRODUCT_BITS-1:0]   product_value;
    logic [imm_pkg::COUNT_BITS-1:0]            op_count;
    logic                                      last;

    modport source (
        output valid, out_row, out_col, product_value, op_count, last,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, product_value, op_count, last,
        output ready
    );
endinterface

// ----- src/integer_matrix_multiply.sv -----
// Integer matrix product C = A x B on matrices of up to MAX_DIM by MAX_DIM
// signed elements of ELEMENT_BITS bits. Each cmd transaction either writes one
// element of A or of B (writes outside the configured sizes are dropped) or
// starts the product; a start returns every element of C in row-major order as
// result transactions, each a full-precision 36-bit sum, and the final one has
// last set and carries the operation count (two per multiply-add). Element
// writes and ignored operation codes are taken while the block is idle. A start
// holds cmd ready low while its rows_a * inner_dim * cols_b multiply-adds run
// and the pipeline drains; one multiply-accumulate unit fed by one read port
// on each matrix memory does one multiply-add per cycle, but the whole pipeline
// holds while a finished result waits on result.ready. The matrix memories
// are not cleared at reset: reading an element that was never written gives
// an undefined result. The size registers (rows_a, inner_dim, cols_b, reset
// to 8) may only be written while no product is in progress; a size of zero
// acts as one and a size above MAX_DIM acts as MAX_DIM.
module integer_matrix_multiply #(
    parameter int MAX_DIM      = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [imm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [imm_pkg::SIZE_BITS-1:0]     cfg_data,
    imm_cmd_if.sink                           cmd,
    imm_result_if.source                      result
);

    localparam int IW = $clog2(MAX_DIM);

    imm_pkg::ctl_t  ctl;
    imm_pkg::stat_t stat;
    logic [IW-1:0]  i_idx, j_idx, k_idx;

    // The controller walks the row, column and inner-term counters and
    // decides which element writes land in the memories.
    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .operation (cmd.operation),
        .row_index (cmd.row_index),
        .col_index (cmd.col_index),
        .ctl       (ctl),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .k_idx     (k_idx),
        .stat      (stat)
    );

    // The datapath holds both matrices, the read, multiply and accumulate
    // stages, the operation counter and the result register.
    imm_datapath #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .i_idx     (i_idx),
        .j_idx     (j_idx),
        .k_idx     (k_idx),
        .wr_row    (cmd.row_index),
        .wr_col    (cmd.col_index),
        .wr_value  (cmd.element_value),
        .stat      (stat),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_row   (result.out_row),
        .res_col   (result.out_col),
        .res_value (result.product_value),
        .res_count (result.op_count),
        .res_last  (result.last)
    );

endmodule

// ----- src/imm_ctrl.sv -----
module imm_ctrl #(
    parameter int MAX_DIM = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [imm_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [imm_pkg::SIZE_BITS-1:0]       cfg_data,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  logic [imm_pkg::OP_BITS-1:0]         operation,
    input  logic [imm_pkg::INDEX_BITS-1:0]      row_index,
    input  logic [imm_pkg::INDEX_BITS-1:0]      col_index,
    output imm_pkg::ctl_t                       ctl,
    output logic [$clog2(MAX_DIM)-1:0]          i_idx,
    output logic [$clog2(MAX_DIM)-1:0]          j_idx,
    output logic [$clog2(MAX_DIM)-1:0]          k_idx,
    input  imm_pkg::stat_t                      stat
);

    localparam int IW = $clog2(MAX_DIM);
    localparam int SW = $clog2(MAX_DIM + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t                          state_reg, state_next;
    logic [imm_pkg::SIZE_BITS-1:0]   rows_reg, rows_next;
    logic [imm_pkg::SIZE_BITS-1:0]   inner_reg, inner_next;
    logic [imm_pkg::SIZE_BITS-1:0]   cols_reg, cols_next;
    logic [IW-1:0]                   i_reg, i_next;
    logic [IW-1:0]                   j_reg, j_next;
    logic [IW-1:0]                   k_reg, k_next;

    logic [SW-1:0] nr, nk, nc;
    logic          accept;
    logic          i_last, j_last, k_last;

    // A size of zero acts as one, a size beyond the storage acts as the maximum.
    function automatic logic [SW-1:0] eff_size(input logic [imm_pkg::SIZE_BITS-1:0] r);
        logic [SW-1:0] v;
        if (r == '0) begin
            v = SW'(1);
        end else if (32'(r) > MAX_DIM) begin
            v = SW'(MAX_DIM);
        end else begin
            v = SW'(r);
        end
        return v;
    endfunction

    assign nr = eff_size(rows_reg);
    assign nk = eff_size(inner_reg);
    assign nc = eff_size(cols_reg);

    assign cmd_ready = (state_reg == S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    assign i_last = (SW'(i_reg) == nr - SW'(1));
    assign j_last = (SW'(j_reg) == nc - SW'(1));
    assign k_last = (SW'(k_reg) == nk - SW'(1));

    assign i_idx = i_reg;
    assign j_idx = j_reg;
    assign k_idx = k_reg;

    always_comb
    begin
        ctl.run    = (state_reg == S_RUN);
        ctl.first  = (k_reg == '0);
        ctl.last_k = k_last;
        ctl.fin    = k_last && j_last && i_last;
        ctl.clear  = accept && (operation == imm_pkg::OP_START);
        ctl.wr_a   = accept && (operation == imm_pkg::OP_WRITE_A)
                     && (row_index < nr) && (col_index < nk);
        ctl.wr_b   = accept && (operation == imm_pkg::OP_WRITE_B)
                     && (row_index < nk) && (col_index < nc);
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == imm_pkg::OP_START))
                begin
                    state_next = S_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            S_RUN:
            begin
                if (!stat.stall)
                begin
                    if (k_last)
                    begin
                        k_next = '0;
                        if (j_last)
                        begin
                            j_next = '0;
                            if (i_last)
                            begin
                                state_next = S_DRAIN;
                            end
                            else
                            begin
                                i_next = i_reg + IW'(1);
                            end
                        end
                        else
                        begin
                            j_next = j_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + IW'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_index)
                imm_pkg::REG_ROWS_A:    rows_next  = cfg_data;
                imm_pkg::REG_INNER_DIM: inner_next = cfg_data;
                imm_pkg::REG_COLS_B:    cols_next  = cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= imm_pkg::SIZE_BITS'(8);
            inner_reg <= imm_pkg::SIZE_BITS'(8);
            cols_reg  <= imm_pkg::SIZE_BITS'(8);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

// ----- src/imm_datapath.sv -----
module imm_datapath #(
    parameter int MAX_DIM      = 8,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  imm_pkg::ctl_t                          ctl,
    input  logic [$clog2(MAX_DIM)-1:0]             i_idx,
    input  logic [$clog2(MAX_DIM)-1:0]             j_idx,
    input  logic [$clog2(MAX_DIM)-1:0]             k_idx,
    input  logic [imm_pkg::INDEX_BITS-1:0]         wr_row,
    input  logic [imm_pkg::INDEX_BITS-1:0]         wr_col,
    input  logic signed [imm_pkg::VALUE_BITS-1:0]  wr_value,
    output imm_pkg::stat_t                         stat,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [imm_pkg::INDEX_BITS-1:0]         res_row,
    output logic [imm_pkg::INDEX_BITS-1:0]         res_col,
    output logic signed [imm_pkg::PRODUCT_BITS-1:0] res_value,
    output logic [imm_pkg::COUNT_BITS-1:0]         res_count,
    output logic                                   res_last
);

    localparam int IW    = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int EB    = ELEMENT_BITS;
    localparam int PB    = imm_pkg::PRODUCT_BITS;
    localparam int CB    = imm_pkg::COUNT_BITS;

    logic signed [EB-1:0] mem_a [DEPTH];
    logic signed [EB-1:0] mem_b [DEPTH];

    logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    logic signed [EB-1:0] wr_elem;
    logic                 advance;

    // Stage 1: element pair read from the two memories.
    logic                 s1_valid_reg;
    logic                 s1_first_reg, s1_last_reg, s1_fin_reg;
    logic [IW-1:0]        s1_i_reg, s1_j_reg;
    logic signed [EB-1:0] a_rd_reg, b_rd_reg;

    // Stage 2: registered product.
    logic                   s2_valid_reg;
    logic                   s2_first_reg, s2_last_reg, s2_fin_reg;
    logic [IW-1:0]          s2_i_reg, s2_j_reg;
    logic signed [2*EB-1:0] prod_reg;

    logic signed [PB-1:0] acc_reg, acc_next;
    logic [CB-1:0]        ops_reg, ops_next;
    logic                 out_valid_reg;

    assign wr_addr   = AW'(IW'(wr_row)) * AW'(MAX_DIM) + AW'(IW'(wr_col));
    assign rd_addr_a = AW'(i_idx) * AW'(MAX_DIM) + AW'(k_idx);
    assign rd_addr_b = AW'(k_idx) * AW'(MAX_DIM) + AW'(j_idx);
    assign wr_elem   = EB'(wr_value);

    // The whole pipeline freezes while a finished element waits to be taken.
    assign advance    = !(out_valid_reg && !res_ready);
    assign stat.stall = !advance;
    assign stat.busy  = s1_valid_reg || s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_a)
        begin
            mem_a[wr_addr] <= wr_elem;
        end
        if (ctl.wr_b)
        begin
            mem_b[wr_addr] <= wr_elem;
        end
        if (advance && ctl.run)
        begin
            a_rd_reg <= mem_a[rd_addr_a];
            b_rd_reg <= mem_b[rd_addr_b];
        end
    end

    always_comb
    begin
        acc_next = s2_first_reg ? PB'(prod_reg) : acc_reg + PB'(prod_reg);
        ops_next = ops_reg + CB'(imm_pkg::OPS_PER_MAC);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_first_reg <= ctl.first;
            s1_last_reg  <= ctl.last_k;
            s1_fin_reg   <= ctl.fin;
            s1_i_reg     <= i_idx;
            s1_j_reg     <= j_idx;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_fin_reg   <= s1_fin_reg;
            s2_i_reg     <= s1_i_reg;
            s2_j_reg     <= s1_j_reg;
            prod_reg     <= a_rd_reg * b_rd_reg;
            if (s2_valid_reg)
            begin
                acc_reg <= acc_next;
            end
            if (s2_valid_reg && s2_last_reg)
            begin
                res_row   <= imm_pkg::INDEX_BITS'(s2_i_reg);
                res_col   <= imm_pkg::INDEX_BITS'(s2_j_reg);
                res_value <= acc_next;
                res_count <= s2_fin_reg ? ops_next : '0;
                res_last  <= s2_fin_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ops_reg       <= '0;
        end
        else
        begin
            if (ctl.clear)
            begin
                ops_reg <= '0;
            end
            else if (advance && s2_valid_reg)
            begin
                ops_reg <= ops_next;
            end
            if (advance)
            begin
                s1_valid_reg  <= ctl.run;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg && s2_last_reg;
            end
        end
    end

    assign res_valid = out_valid_reg;

endmodule

// ----- src/imm_checker.sv -----
module imm_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cmd_valid,
    input logic                                    cmd_ready,
    input logic [imm_pkg::OP_BITS-1:0]             operation,
    input logic                                    res_valid,
    input logic                                    res_ready,
    input logic signed [imm_pkg::PRODUCT_BITS-1:0] product_value,
    input logic [imm_pkg::COUNT_BITS-1:0]          op_count,
    input logic                                    last
);

    // A waiting result stays and keeps its value.
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(product_value)
    ) else $error("result dropped or changed while stalled");

    // An accepted start takes the block busy on the next cycle.
    a_start_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (operation == imm_pkg::OP_START) |=> !cmd_ready
    ) else $error("command accepted right after a start");

    // While a product element other than the last is shown, the product is
    // still being computed, so no command is taken.
    a_busy_mid_product: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> !cmd_ready
    ) else $error("command ready in the middle of a product");

    // Only the last element carries the operation count.
    a_count_on_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> op_count == '0
    ) else $error("operation count on an element that is not the last");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .operation     (cmd.operation),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .product_value (result.product_value),
    .op_count      (result.op_count),
    .last          (result.last)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for integer_matrix_multiply.
//
// Element writes and starts go in over the cmd channel, one transaction per
// item. Each accepted item is also fed to a predictor that keeps its own copy
// of A, of B and of the three size registers, and a start pushes every
// element of the expected product onto a queue in row-major order. The
// result process pops the oldest expected element for every accepted result
// transaction and compares it field by field.
//
// The matrix memories hold garbage until written. The bench therefore keeps
// a flag for every entry and fills any entry that a start would read before
// it sends that start. Writes that fall outside the configured sizes and the
// unused operation code are still sent, but they never set a flag.
//
// The size registers are written only while the block is idle, that is after
// the sender has stopped, every expected element has come back, and a few
// more cycles have passed for writes still in flight inside the block.
module tb_top;

    localparam int          MAX_DIM       = 8;
    localparam int          RANDOM_ITEMS  = 110;
    localparam int          SETTLE_CYCLES = 6;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          MAX_GAP       = 10;
    localparam int          CHECK_BITS    = imm_pkg::PRODUCT_BITS + 1;
    localparam logic [imm_pkg::OP_BITS-1:0]            OP_UNUSED = 2'd3;
    localparam logic signed [imm_pkg::VALUE_BITS-1:0]  VALUE_MAX = 16'sh7fff;
    localparam logic signed [imm_pkg::VALUE_BITS-1:0]  VALUE_MIN = 16'sh8000;
    // A size of zero acts as one and anything above MAX_DIM acts as MAX_DIM.
    localparam logic [imm_pkg::SIZE_BITS-1:0]          SIZE_ZERO = 4'd0;
    localparam logic [imm_pkg::SIZE_BITS-1:0]          SIZE_TOP  = 4'd15;

    // One element of the expected product.
    typedef struct {
        logic [imm_pkg::INDEX_BITS-1:0]          row;
        logic [imm_pkg::INDEX_BITS-1:0]          col;
        logic signed [imm_pkg::PRODUCT_BITS-1:0] value;
        logic [imm_pkg::COUNT_BITS-1:0]          ops;
        logic                                    last;
    } product_elem_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [imm_pkg::CFG_IDX_BITS-1:0]   cfg_index;
    logic [imm_pkg::SIZE_BITS-1:0]      cfg_data;

    imm_cmd_if    cmd_ch ();
    imm_result_if res_ch ();

    integer_matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .result    (res_ch)
    );

    // Predictor state: the matrices as the block should hold them, which
    // entries have really been written, and the current size registers.
    logic signed [imm_pkg::VALUE_BITS-1:0] model_a [MAX_DIM*MAX_DIM];
    logic signed [imm_pkg::VALUE_BITS-1:0] model_b [MAX_DIM*MAX_DIM];
    bit                                    a_known [MAX_DIM*MAX_DIM];
    bit                                    b_known [MAX_DIM*MAX_DIM];
    logic [imm_pkg::SIZE_BITS-1:0]         size_rows;
    logic [imm_pkg::SIZE_BITS-1:0]         size_inner;
    logic [imm_pkg::SIZE_BITS-1:0]         size_cols;

    product_elem_t expected_products [$];
    int            fail_count;
    int            live_commands;

    // Random idling of the two sides; a test turns them off to get stretches
    // of back-to-back transactions.
    bit cmd_gaps;
    bit res_gaps;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic int eff_dim(input logic [imm_pkg::SIZE_BITS-1:0] size);
        if (size == 0)
            return 1;
        if (size > MAX_DIM)
            return MAX_DIM;
        return int'(size);
    endfunction

    // Values lean toward the extremes so that the widest sums show up often.
    function automatic logic signed [imm_pkg::VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return imm_pkg::VALUE_BITS'($urandom);
        endcase
    endfunction

    // Update the predictor for one accepted cmd transaction. A start queues
    // the whole product; writes outside the sizes and the unused code change
    // nothing.
    function automatic void apply_command(
        input logic [imm_pkg::OP_BITS-1:0]           code,
        input logic [imm_pkg::INDEX_BITS-1:0]        row,
        input logic [imm_pkg::INDEX_BITS-1:0]        col,
        input logic signed [imm_pkg::VALUE_BITS-1:0] value);
        int            nr;
        int            nk;
        int            nc;
        int            i;
        int            j;
        int            k;
        longint        acc;
        product_elem_t elem;
        nr = eff_dim(size_rows);
        nk = eff_dim(size_inner);
        nc = eff_dim(size_cols);
        if (code == imm_pkg::OP_WRITE_A)
        begin
            if (row < nr && col < nk)
            begin
                model_a[row*MAX_DIM + col] = value;
                a_known[row*MAX_DIM + col] = 1'b1;
                live_commands++;
            end
        end
        else if (code == imm_pkg::OP_WRITE_B)
        begin
            if (row < nk && col < nc)
            begin
                model_b[row*MAX_DIM + col] = value;
                b_known[row*MAX_DIM + col] = 1'b1;
                live_commands++;
            end
        end
        else if (code == imm_pkg::OP_START)
        begin
            live_commands++;
            for (i = 0; i < nr; i++)
            begin
                for (j = 0; j < nc; j++)
                begin
                    acc = 0;
                    for (k = 0; k < nk; k++)
                        acc += longint'(model_a[i*MAX_DIM + k]) *
                               longint'(model_b[k*MAX_DIM + j]);
                    elem.row   = imm_pkg::INDEX_BITS'(i);
                    elem.col   = imm_pkg::INDEX_BITS'(j);
                    elem.value = acc[imm_pkg::PRODUCT_BITS-1:0];
                    elem.last  = (i == nr - 1) && (j == nc - 1);
                    elem.ops   = elem.last ?
                        imm_pkg::COUNT_BITS'(imm_pkg::OPS_PER_MAC * nr * nk * nc) : '0;
                    expected_products.push_back(elem);
                end
            end
        end
    endfunction

    // Send one cmd transaction after a random gap and wait for it to be taken.
    // The task returns at the clock edge of the handshake without lowering
    // valid, so a following item with no gap keeps valid high throughout.
    task automatic send_command(
        input logic [imm_pkg::OP_BITS-1:0]           code,
        input logic [imm_pkg::INDEX_BITS-1:0]        row,
        input logic [imm_pkg::INDEX_BITS-1:0]        col,
        input logic signed [imm_pkg::VALUE_BITS-1:0] value);
        int gap;
        gap = draw_gap(cmd_gaps);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid         <= 1'b1;
        cmd_ch.operation     <= code;
        cmd_ch.row_index     <= row;
        cmd_ch.col_index     <= col;
        cmd_ch.element_value <= value;
        do
            @(posedge clk);
        while (!(cmd_ch.valid && cmd_ch.ready));
        apply_command(code, row, col, value);
    endtask

    task automatic send_start();
        send_command(imm_pkg::OP_START, imm_pkg::INDEX_BITS'($urandom),
                     imm_pkg::INDEX_BITS'($urandom), imm_pkg::VALUE_BITS'($urandom));
    endtask

    // Stop sending, wait for the last expected element, and give writes still
    // inside the block time to land before the sizes change.
    task automatic drain_and_settle();
        cmd_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three size registers on consecutive cycles; the block must
    // be idle. The predictor takes the new values at once.
    task automatic set_sizes(input logic [imm_pkg::SIZE_BITS-1:0] rows,
                             input logic [imm_pkg::SIZE_BITS-1:0] inner,
                             input logic [imm_pkg::SIZE_BITS-1:0] cols);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_index <= imm_pkg::REG_ROWS_A;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_index <= imm_pkg::REG_INNER_DIM;
        cfg_data  <= inner;
        @(posedge clk);
        cfg_index <= imm_pkg::REG_COLS_B;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_we <= 1'b0;
        size_rows  = rows;
        size_inner = inner;
        size_cols  = cols;
    endtask

    // Write every entry that the next start reads and that has never been
    // written, so that no start ever sees an undefined element.
    task automatic fill_operands();
        int r;
        int c;
        for (r = 0; r < eff_dim(size_rows); r++)
            for (c = 0; c < eff_dim(size_inner); c++)
                if (!a_known[r*MAX_DIM + c])
                    send_command(imm_pkg::OP_WRITE_A, imm_pkg::INDEX_BITS'(r),
                                 imm_pkg::INDEX_BITS'(c), pick_value());
        for (r = 0; r < eff_dim(size_inner); r++)
            for (c = 0; c < eff_dim(size_cols); c++)
                if (!b_known[r*MAX_DIM + c])
                    send_command(imm_pkg::OP_WRITE_B, imm_pkg::INDEX_BITS'(r),
                                 imm_pkg::INDEX_BITS'(c), pick_value());
    endtask

    // Mostly writes inside the current sizes, some writes to any address
    // (which may be dropped) and now and then the unused operation code.
    task automatic send_random_item();
        int pick;
        int nr;
        int nk;
        int nc;
        pick = $urandom_range(0, 19);
        nr   = eff_dim(size_rows);
        nk   = eff_dim(size_inner);
        nc   = eff_dim(size_cols);
        if (pick < 7)
            send_command(imm_pkg::OP_WRITE_A,
                         imm_pkg::INDEX_BITS'($urandom_range(0, nr - 1)),
                         imm_pkg::INDEX_BITS'($urandom_range(0, nk - 1)), pick_value());
        else if (pick < 14)
            send_command(imm_pkg::OP_WRITE_B,
                         imm_pkg::INDEX_BITS'($urandom_range(0, nk - 1)),
                         imm_pkg::INDEX_BITS'($urandom_range(0, nc - 1)), pick_value());
        else if (pick < 18)
            send_command(pick[0] ? imm_pkg::OP_WRITE_A : imm_pkg::OP_WRITE_B,
                         imm_pkg::INDEX_BITS'($urandom),
                         imm_pkg::INDEX_BITS'($urandom), pick_value());
        else
            send_command(OP_UNUSED, imm_pkg::INDEX_BITS'($urandom),
                         imm_pkg::INDEX_BITS'($urandom), imm_pkg::VALUE_BITS'($urandom));
    endtask

    // Sizes for a random phase: mostly small so that products stay short,
    // with zero, the largest code and the full size now and then.
    function automatic logic [imm_pkg::SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 9))
            6: return SIZE_ZERO;
            7: return SIZE_TOP;
            8: return imm_pkg::SIZE_BITS'(MAX_DIM);
            9: return imm_pkg::SIZE_BITS'($urandom_range(0, 15));
            default: return imm_pkg::SIZE_BITS'($urandom_range(1, 4));
        endcase
    endfunction

    // Directed corners: extreme element values, every operation code, writes
    // just outside the sizes and at the highest indexes, and a one by one
    // product set through size registers of zero. No idling here.
    task automatic test_directed_corners();
        cmd_gaps = 1'b0;
        res_gaps = 1'b0;
        set_sizes(4'd2, 4'd2, 4'd2);
        send_command(imm_pkg::OP_WRITE_A, 3'd0, 3'd0, VALUE_MAX);
        send_command(imm_pkg::OP_WRITE_A, 3'd0, 3'd1, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_A, 3'd1, 3'd0, -16'sd1);
        send_command(imm_pkg::OP_WRITE_A, 3'd1, 3'd1, 16'sd0);
        send_command(imm_pkg::OP_WRITE_B, 3'd0, 3'd0, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_B, 3'd0, 3'd1, VALUE_MAX);
        send_command(imm_pkg::OP_WRITE_B, 3'd1, 3'd0, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_B, 3'd1, 3'd1, 16'sd1);
        // Each of these lies outside the 2x2 sizes and must leave A and B alone.
        send_command(imm_pkg::OP_WRITE_A, 3'd2, 3'd0, VALUE_MAX);
        send_command(imm_pkg::OP_WRITE_A, 3'd7, 3'd7, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_B, 3'd0, 3'd7, VALUE_MAX);
        send_command(imm_pkg::OP_WRITE_B, 3'd2, 3'd1, -16'sd1);
        // The unused code is dropped with no result.
        send_command(OP_UNUSED, 3'd7, 3'd7, VALUE_MAX);
        send_command(imm_pkg::OP_START, 3'd7, 3'd7, -16'sd1);
        // Zero sizes act as one: a single element with an operation count of two.
        set_sizes(SIZE_ZERO, SIZE_ZERO, SIZE_ZERO);
        send_command(imm_pkg::OP_WRITE_A, 3'd0, 3'd0, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_B, 3'd0, 3'd0, VALUE_MIN);
        send_command(imm_pkg::OP_WRITE_A, 3'd0, 3'd1, VALUE_MAX);
        send_command(imm_pkg::OP_START, 3'd0, 3'd0, 16'sd0);
    endtask

    // The largest product, rows and columns set through the top size code: every
    // entry of A and B rewritten, then two starts back to back, both sides idling.
    task automatic test_largest_product();
        int r;
        int c;
        set_sizes(SIZE_TOP, imm_pkg::SIZE_BITS'(MAX_DIM), SIZE_TOP);
        cmd_gaps = 1'b1;
        res_gaps = 1'b1;
        for (r = 0; r < MAX_DIM; r++)
            for (c = 0; c < MAX_DIM; c++)
            begin
                send_command(imm_pkg::OP_WRITE_A, imm_pkg::INDEX_BITS'(r),
                             imm_pkg::INDEX_BITS'(c), pick_value());
                send_command(imm_pkg::OP_WRITE_B, imm_pkg::INDEX_BITS'(r),
                             imm_pkg::INDEX_BITS'(c), pick_value());
            end
        send_start();
        send_start();
    endtask

    // Random phases: new sizes, a burst of writes and noise, any missing
    // operands, then one or two starts and sometimes a few writes that queue
    // up behind the product while it is being computed.
    task automatic test_random_products(input int target);
        int base;
        int n;
        base = live_commands;
        while (live_commands - base < target)
        begin
            set_sizes(pick_size(), pick_size(), pick_size());
            cmd_gaps = ($urandom_range(0, 3) != 0);
            res_gaps = ($urandom_range(0, 3) != 0);
            n = $urandom_range(0, 12);
            repeat (n) send_random_item();
            fill_operands();
            send_start();
            if ($urandom_range(0, 2) == 0)
                send_start();
            n = $urandom_range(0, 3);
            repeat (n) send_random_item();
        end
    endtask

    task automatic check_field(input string name, input logic signed [CHECK_BITS-1:0] want,
                               input logic signed [CHECK_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: draw a stall before each result transaction and compare
    // every accepted one against the oldest expected element. Ready is raised
    // right at the edge that takes a result when no stall is drawn, so it
    // never drops and rises within one time step.
    initial
    begin : result_sink
        int            stall;
        product_elem_t want;
        stall = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_products.size() == 0)
                begin
                    $error("result transaction with nothing expected: row %0d col %0d",
                           res_ch.out_row, res_ch.out_col);
                    fail_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    check_field("out_row", CHECK_BITS'(want.row),
                                CHECK_BITS'(res_ch.out_row));
                    check_field("out_col", CHECK_BITS'(want.col),
                                CHECK_BITS'(res_ch.out_col));
                    check_field("product_value", CHECK_BITS'(want.value),
                                CHECK_BITS'(res_ch.product_value));
                    check_field("op_count", CHECK_BITS'(want.ops),
                                CHECK_BITS'(res_ch.op_count));
                    check_field("last", CHECK_BITS'(want.last),
                                CHECK_BITS'(res_ch.last));
                end
                stall = draw_gap(res_gaps);
                if (stall > 0)
                    res_ch.ready <= 1'b0;
            end
            else if (!res_ch.ready && rst_n)
            begin
                if (stall > 0)
                    stall--;
                if (stall == 0)
                    res_ch.ready <= 1'b1;
            end
        end
    end

    // The run ends here if nothing is accepted on either channel for too
    // long; the longest correct gap is a full-size element under stall.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("integer_matrix_multiply regression: fail");
        $finish;
    end

    initial
    begin : run_tests
        fail_count    = 0;
        live_commands = 0;
        cmd_gaps      = 1'b0;
        res_gaps      = 1'b0;
        size_rows     = imm_pkg::SIZE_BITS'(MAX_DIM);
        size_inner    = imm_pkg::SIZE_BITS'(MAX_DIM);
        size_cols     = imm_pkg::SIZE_BITS'(MAX_DIM);
        foreach (a_known[i])
        begin
            a_known[i] = 1'b0;
            b_known[i] = 1'b0;
        end
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= imm_pkg::REG_ROWS_A;
        cfg_data             <= '0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.operation     <= imm_pkg::OP_WRITE_A;
        cmd_ch.row_index     <= '0;
        cmd_ch.col_index     <= '0;
        cmd_ch.element_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_products(RANDOM_ITEMS / 2);
        test_largest_product();
        test_random_products(RANDOM_ITEMS / 2);

        // Everything has been sent; wait for the tail of the last product.
        cmd_ch.valid <= 1'b0;
        while (expected_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("integer_matrix_multiply regression: pass");
        else
            $display("integer_matrix_multiply regression: fail");
        $finish;
    end

endmodule
